// ===== sv/h2c_pkg.sv =====
// ----------------------------------------------------------------------------
// h2c_pkg
// shared widths, constants and types of the hsl to cmyk pixel converter
// ----------------------------------------------------------------------------
package h2c_pkg;

   localparam int unsigned PIX_W = 8;
   localparam int unsigned LANES = 3;

   // q, p and their difference over 255*255
   localparam int unsigned FRAC_W = 17;
   // channels over 255*255*128
   localparam int unsigned CHAN_W = 23;
   localparam int unsigned CH_SHIFT = 7;
   localparam int unsigned NUM_W = 32;
   localparam int unsigned DVS_W = CHAN_W + 1;
   localparam int unsigned KEYP_W = CHAN_W - CH_SHIFT;
   localparam int unsigned HPOS_W = 10;
   localparam int unsigned WGT_W = 8;

   localparam int unsigned RGB_STAGES = 2;
   localparam int unsigned NORM_STAGES = 2;
   localparam int unsigned FRONT_STAGES = RGB_STAGES + NORM_STAGES;
   localparam int unsigned DIV_STAGES = PIX_W;
   localparam int unsigned STAGES = FRONT_STAGES + DIV_STAGES;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [FRAC_W-1:0] frac_type;
   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [NUM_W-1:0] num_type;
   typedef logic [DVS_W-1:0] dvs_type;
   typedef logic [KEYP_W-1:0] keyp_type;
   typedef logic [HPOS_W-1:0] hpos_type;
   typedef logic [WGT_W-1:0] wgt_type;

   localparam pix_type PIX_MAX = 8'd255;
   localparam pix_type LIGHT_HALF = 8'd128;

   // hue position over 768
   localparam hpos_type HUE_SIXTH = 10'd128;
   localparam hpos_type HUE_THIRD = 10'd256;
   localparam hpos_type HUE_HALF = 10'd384;
   localparam hpos_type HUE_TWO_THIRDS = 10'd512;
   localparam hpos_type HUE_TURN = 10'd768;

   localparam chan_type CH_DEN = 23'd8323200;
   // half of 255*128, rounds the key
   localparam chan_type KEY_BIAS = 23'd16320;

   // lane 0 red / cyan, lane 1 green / magenta, lane 2 blue / yellow
   typedef chan_type [LANES-1:0] rgb_type;

   typedef struct packed {
      num_type [LANES-1:0] numer;
      dvs_type divisor;
      keyp_type key_pre;
      logic black;
   } norm_type;

   typedef struct packed {
      pix_type cyan;
      pix_type magenta;
      pix_type yellow;
      pix_type key_black;
   } cmyk_type;

endpackage

// ===== sv/h2c_if.sv =====
// ----------------------------------------------------------------------------
// h2c_req_if / h2c_rsp_if
// valid/ready channels carrying one hsl word in and one cmyk word out
// ----------------------------------------------------------------------------
interface h2c_req_if import h2c_pkg::*; ();
   logic valid;
   logic ready;
   pix_type hue;
   pix_type saturation;
   pix_type lightness;

   modport source (output valid, hue, saturation, lightness, input ready);
   modport sink (input valid, hue, saturation, lightness, output ready);
endinterface

interface h2c_rsp_if import h2c_pkg::*; ();
   logic valid;
   logic ready;
   pix_type cyan;
   pix_type magenta;
   pix_type yellow;
   pix_type key_black;

   modport source (output valid, cyan, magenta, yellow, key_black, input ready);
   modport sink (input valid, cyan, magenta, yellow, key_black, output ready);
endinterface

// ===== sv/h2c_rgb.sv =====
// ----------------------------------------------------------------------------
// h2c_rgb
// two stages: hsl to q/p and hue weights, then the three rgb channels
// ----------------------------------------------------------------------------
module h2c_rgb import h2c_pkg::*; (
   input  logic                  clock,
   input  logic [RGB_STAGES-1:0] en,
   input  pix_type               hue,
   input  pix_type               saturation,
   input  pix_type               lightness,
   output rgb_type               rgb
);

   function automatic wgt_type weight_of(input hpos_type t);
      hpos_type fall;
      fall = HUE_TWO_THIRDS - t;
      if (t < HUE_SIXTH) begin
         weight_of = wgt_type'(t);
      end else if (t < HUE_HALF) begin
         weight_of = wgt_type'(HUE_SIXTH);
      end else if (t < HUE_TWO_THIRDS) begin
         weight_of = wgt_type'(fall);
      end else begin
         weight_of = '0;
      end
   endfunction

   logic [2*PIX_W-1:0] ls;
   frac_type l255, s255, ls_w;
   frac_type p_in, d_in, p_ff, d_ff;
   hpos_type th, t_red, t_blue;
   hpos_type t_pos [LANES];
   wgt_type w_ff [LANES];
   rgb_type rgb_ff;

   assign ls = lightness * saturation;
   assign ls_w = frac_type'(ls);
   assign l255 = frac_type'({lightness, {PIX_W{1'b0}}}) - frac_type'(lightness);
   assign s255 = frac_type'({saturation, {PIX_W{1'b0}}}) - frac_type'(saturation);

   // d is q - p
   always_comb begin
      if (lightness < LIGHT_HALF) begin
         p_in = l255 - ls_w;
         d_in = {ls_w[FRAC_W-2:0], 1'b0};
      end else begin
         p_in = l255 + ls_w - s255;
         d_in = frac_type'({s255 - ls_w, 1'b0});
      end
   end

   assign th = hpos_type'({hue, 1'b0}) + hpos_type'(hue);
   assign t_red = (th + HUE_THIRD > HUE_TURN) ? th + HUE_THIRD - HUE_TURN : th + HUE_THIRD;
   assign t_blue = (th < HUE_THIRD) ? th + HUE_TWO_THIRDS : th - HUE_THIRD;
   assign t_pos[0] = t_red;
   assign t_pos[1] = th;
   assign t_pos[2] = t_blue;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p_ff <= p_in;
         d_ff <= d_in;
         for (int c = 0; c < LANES; c++) begin
            w_ff[c] <= weight_of(t_pos[c]);
         end
      end
   end

   for (genvar c = 0; c < LANES; c++) begin : g_lane
      logic [FRAC_W+WGT_W-1:0] prod, sum;
      assign prod = d_ff * w_ff[c];
      assign sum = prod + (FRAC_W+WGT_W)'({p_ff, {CH_SHIFT{1'b0}}});

      always_ff @(posedge clock) begin
         if (en[1]) begin
            rgb_ff[c] <= sum[CHAN_W-1:0];
         end
      end
   end

   assign rgb = rgb_ff;

endmodule

// ===== sv/h2c_norm.sv =====
// ----------------------------------------------------------------------------
// h2c_norm
// two stages: brightest channel, then ink numerators, divisor and key
// ----------------------------------------------------------------------------
module h2c_norm import h2c_pkg::*; (
   input  logic                   clock,
   input  logic [NORM_STAGES-1:0] en,
   input  rgb_type                rgb,
   output norm_type               norm
);

   chan_type mx_in, mx_ff;
   rgb_type rgb_ff;
   chan_type kb;
   norm_type norm_in, norm_ff;

   always_comb begin
      mx_in = rgb[0];
      if (rgb[1] > mx_in) begin
         mx_in = rgb[1];
      end
      if (rgb[2] > mx_in) begin
         mx_in = rgb[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mx_ff <= mx_in;
         rgb_ff <= rgb;
      end
   end

   assign kb = CH_DEN - mx_ff + KEY_BIAS;

   // numerator (mx - ch) * 510 + mx, ink = numerator / (2 * mx)
   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         norm_in.numer[c] = (num_type'(mx_ff - rgb_ff[c]) << 9)
                          - (num_type'(mx_ff - rgb_ff[c]) << 1)
                          + num_type'(mx_ff);
      end
      norm_in.divisor = {mx_ff, 1'b0};
      norm_in.key_pre = kb[CHAN_W-1:CH_SHIFT];
      norm_in.black = (mx_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         norm_ff <= norm_in;
      end
   end

   assign norm = norm_ff;

endmodule

// ===== sv/h2c_div.sv =====
// ----------------------------------------------------------------------------
// h2c_div
// restoring divider, one quotient bit per stage for three inks, with the
// key divided by 255 alongside
// ----------------------------------------------------------------------------
module h2c_div import h2c_pkg::*; (
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] en,
   input  norm_type              norm,
   output cmyk_type              cmyk
);

   num_type rem_src [DIV_STAGES][LANES];
   pix_type quo_src [DIV_STAGES][LANES];
   dvs_type dvs_src [DIV_STAGES];
   logic black_src [DIV_STAGES];

   num_type rem_ff [DIV_STAGES-1][LANES];
   pix_type quo_ff [DIV_STAGES][LANES];
   dvs_type dvs_ff [DIV_STAGES-1];
   logic black_ff [DIV_STAGES-1];

   logic [KEYP_W+PIX_W-1:0] kprod;
   keyp_type key_y_ff, kmul, krem;
   pix_type key_est_ff;
   pix_type key_ff [1:DIV_STAGES-1];

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
      localparam int unsigned BIT = DIV_STAGES - 1 - j;

      if (j == 0) begin : g_head
         assign dvs_src[j] = norm.divisor;
         assign black_src[j] = norm.black;
         for (genvar c = 0; c < LANES; c++) begin : g_src
            assign rem_src[j][c] = norm.numer[c];
            assign quo_src[j][c] = '0;
         end
      end else begin : g_body
         assign dvs_src[j] = dvs_ff[j-1];
         assign black_src[j] = black_ff[j-1];
         for (genvar c = 0; c < LANES; c++) begin : g_src
            assign rem_src[j][c] = rem_ff[j-1][c];
            assign quo_src[j][c] = quo_ff[j-1][c];
         end
      end

      for (genvar c = 0; c < LANES; c++) begin : g_lane
         num_type shd, rem_in;
         pix_type quo_in;
         logic take;

         assign shd = num_type'(dvs_src[j]) << BIT;
         assign take = (rem_src[j][c] >= shd);
         assign rem_in = take ? rem_src[j][c] - shd : rem_src[j][c];
         assign quo_in = quo_src[j][c] | (take ? (pix_type'(1) << BIT) : '0);

         if (j < DIV_STAGES - 1) begin : g_mid
            always_ff @(posedge clock) begin
               if (en[j]) begin
                  rem_ff[j][c] <= rem_in;
                  quo_ff[j][c] <= quo_in;
               end
            end
         end else begin : g_last
            // no brightness at all: no ink
            always_ff @(posedge clock) begin
               if (en[j]) begin
                  quo_ff[j][c] <= black_src[j] ? '0 : quo_in;
               end
            end
         end
      end

      if (j < DIV_STAGES - 1) begin : g_ctl
         always_ff @(posedge clock) begin
            if (en[j]) begin
               dvs_ff[j] <= dvs_src[j];
               black_ff[j] <= black_src[j];
            end
         end
      end
   end

   // key = floor(y / 255): y * 257 >> 16 is low by at most one
   assign kprod = {norm.key_pre, {PIX_W{1'b0}}} + (KEYP_W+PIX_W)'(norm.key_pre);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         key_y_ff <= norm.key_pre;
         key_est_ff <= kprod[KEYP_W+PIX_W-1 -: PIX_W];
      end
   end

   assign kmul = keyp_type'({key_est_ff, {PIX_W{1'b0}}}) - keyp_type'(key_est_ff);
   assign krem = key_y_ff - kmul;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         key_ff[1] <= key_est_ff + pix_type'(krem >= keyp_type'(PIX_MAX));
      end
   end

   for (genvar j = 2; j < DIV_STAGES; j++) begin : g_key
      always_ff @(posedge clock) begin
         if (en[j]) begin
            key_ff[j] <= key_ff[j-1];
         end
      end
   end

   assign cmyk.cyan = quo_ff[DIV_STAGES-1][0];
   assign cmyk.magenta = quo_ff[DIV_STAGES-1][1];
   assign cmyk.yellow = quo_ff[DIV_STAGES-1][2];
   assign cmyk.key_black = key_ff[DIV_STAGES-1];

endmodule

// ===== sv/hsl_to_cmyk_pixel.sv =====
// ----------------------------------------------------------------------------
// hsl_to_cmyk_pixel
// an accepted word passes the rgb, norm and divider stages before its result shows on rsp_chan
// throughput: one pixel per cycle while rsp_chan is not stalled; the 8-stage ink divider sets the depth
// a stalled output holds only the stages behind it until a bubble is filled
// reset clears the stage valid bits; the data registers are not reset
// ----------------------------------------------------------------------------
module hsl_to_cmyk_pixel import h2c_pkg::*; (
   input logic        clock,
   input logic        reset,
   h2c_req_if.sink    req_chan,
   h2c_rsp_if.source  rsp_chan
);

   logic [STAGES-1:0] v_ff, v_in, en;
   rgb_type rgb;
   norm_type norm;
   cmyk_type cmyk;

   // a stage moves when the output is ready, or when it or some stage after it is empty
   for (genvar k = 0; k < STAGES; k++) begin : g_en
      assign en[k] = rsp_chan.ready || !(&v_ff[STAGES-1:k]);
   end

   always_comb begin
      v_in[0] = en[0] ? req_chan.valid : v_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   h2c_rgb u_rgb (
      .clock      (clock),
      .en         (en[RGB_STAGES-1:0]),
      .hue        (req_chan.hue),
      .saturation (req_chan.saturation),
      .lightness  (req_chan.lightness),
      .rgb        (rgb)
   );

   h2c_norm u_norm (
      .clock (clock),
      .en    (en[FRONT_STAGES-1:RGB_STAGES]),
      .rgb   (rgb),
      .norm  (norm)
   );

   h2c_div u_div (
      .clock (clock),
      .en    (en[STAGES-1:FRONT_STAGES]),
      .norm  (norm),
      .cmyk  (cmyk)
   );

   assign req_chan.ready = en[0];
   assign rsp_chan.valid = v_ff[STAGES-1];
   assign rsp_chan.cyan = cmyk.cyan;
   assign rsp_chan.magenta = cmyk.magenta;
   assign rsp_chan.yellow = cmyk.yellow;
   assign rsp_chan.key_black = cmyk.key_black;

   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> v_ff[0])
      else $error("accepted word did not enter the first stage");

   a_free_output_takes : assert property (@(posedge clock) disable iff (reset)
      !rsp_chan.valid || rsp_chan.ready |-> req_chan.ready)
      else $error("input stalled while the output was free");

   a_black_no_ink : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.key_black == PIX_MAX |->
         rsp_chan.cyan == '0 && rsp_chan.magenta == '0 && rsp_chan.yellow == '0)
      else $error("ink on a full black pixel");

   a_one_ink_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         rsp_chan.cyan == '0 || rsp_chan.magenta == '0 || rsp_chan.yellow == '0)
      else $error("brightest channel gave a nonzero ink");

endmodule
